/* hdl/fubb_pkg.sv */
package fubb_pkg;

  localparam int BUF_DEPTH_DEF   = 512;
  localparam int QUEUE_DEPTH_DEF = 4;
  localparam int CAP_W           = 10;

  localparam logic [CAP_W-1:0] CAP_RESET = 10'd512;

  localparam logic [2:0] ACT_CLEAR = 3'd0;
  localparam logic [2:0] ACT_NAME  = 3'd1;
  localparam logic [2:0] ACT_TEXT  = 3'd2;
  localparam logic [2:0] ACT_BIN   = 3'd3;
  localparam logic [2:0] ACT_END   = 3'd4;
  localparam logic [2:0] ACT_READ  = 3'd5;

  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_NO_ROOM   = 2'd1;
  localparam logic [1:0] ST_NO_NAME   = 2'd2;
  localparam logic [1:0] ST_EMPTY_VAL = 2'd3;

  localparam logic [7:0] CH_AMP     = 8'h26;
  localparam logic [7:0] CH_EQ      = 8'h3D;
  localparam logic [7:0] CH_PLUS    = 8'h2B;
  localparam logic [7:0] CH_PCT     = 8'h25;
  localparam logic [7:0] CH_SPACE   = 8'h20;
  localparam logic [7:0] CH_ZERO    = 8'h30;
  localparam logic [7:0] CH_NINE    = 8'h39;
  localparam logic [7:0] CH_A_UP    = 8'h41;
  localparam logic [7:0] CH_Z_UP    = 8'h5A;
  localparam logic [7:0] CH_A_LOW   = 8'h61;
  localparam logic [7:0] CH_Z_LOW   = 8'h7A;

  typedef logic [CAP_W-1:0] cap_t;

  typedef struct packed {
    logic [2:0] action;
    logic [7:0] data_byte;
    logic [8:0] read_index;
  } in_item_t;

  typedef struct packed {
    logic [1:0] status;
    logic [7:0] read_data;
    logic [8:0] body_length;
    logic       overflow_seen;
  } out_item_t;

  // Up to three encoded bytes, first byte in the top lane.
  typedef struct packed {
    logic [23:0] bytes;
    logic [1:0]  n;
  } enc_t;

  // One request as handed from the front to the back.
  typedef struct packed {
    logic [2:0]  n_bytes;
    logic [31:0] bytes;
    logic        read_hit;
    out_item_t   res;
  } op_t;

  function automatic logic [7:0] hex_digit(input logic [3:0] v);
    if (v <= 4'd9) begin
      return CH_ZERO + {4'h0, v};
    end
    return CH_A_UP + {4'h0, v} - 8'd10;
  endfunction

  function automatic enc_t encode_text(input logic [7:0] c);
    enc_t e;
    logic alnum;
    alnum = (c >= CH_ZERO && c <= CH_NINE) || (c >= CH_A_UP && c <= CH_Z_UP) ||
            (c >= CH_A_LOW && c <= CH_Z_LOW);
    if (alnum) begin
      e.bytes = {c, 16'h0000};
      e.n     = 2'd1;
    end else if (c == CH_SPACE) begin
      e.bytes = {CH_PLUS, 16'h0000};
      e.n     = 2'd1;
    end else begin
      e.bytes = {CH_PCT, hex_digit(c[7:4]), hex_digit(c[3:0])};
      e.n     = 2'd3;
    end
    return e;
  endfunction

  function automatic enc_t encode_hex(input logic [7:0] c);
    enc_t e;
    e.bytes = {hex_digit(c[7:4]), hex_digit(c[3:0]), 8'h00};
    e.n     = 2'd2;
    return e;
  endfunction

endpackage

/* hdl/form_urlencoded_body_builder.sv */
// Channel  Direction  Ports                               Payload
// in       input      in_valid, in_ready, in_data         action, data_byte, read_index
// out      output     out_valid, out_ready, out_data      status, read_data, body_length,
//                                                         overflow_seen
// cfg      input      cfg_valid, cfg_ready, cfg_capacity  capacity
//
// The front takes one request per cycle while its queue has room; the back then
// writes the stored bytes of a request one at a time and takes the next request
// only after the last, as the body store has a single write port.
// A request's result goes to the p1 stage after its last step, then to the output register.
// Reset is synchronous and clears all control state; the body store is not cleared.
// Output stalls fill the output and p1 stages, then the queue, before in_ready drops.
module form_urlencoded_body_builder #(
  parameter int BUF_DEPTH   = fubb_pkg::BUF_DEPTH_DEF,
  parameter int QUEUE_DEPTH = fubb_pkg::QUEUE_DEPTH_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  fubb_pkg::in_item_t  in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output fubb_pkg::out_item_t out_data,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  fubb_pkg::cap_t      cfg_capacity
);

  import fubb_pkg::*;

  localparam int AW = $clog2(BUF_DEPTH);
  localparam int QW = $bits(op_t) + AW;

  logic          q_full;
  logic          q_push;
  op_t           push_op;
  logic [AW-1:0] push_addr;
  logic          q_pop;
  logic          q_valid;
  logic [QW-1:0] q_head;
  op_t           head_op;
  logic [AW-1:0] head_addr;

  fubb_front #(
    .BUF_DEPTH (BUF_DEPTH)
  ) u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_data      (in_data),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_capacity (cfg_capacity),
    .q_full       (q_full),
    .q_push       (q_push),
    .q_op         (push_op),
    .q_addr       (push_addr)
  );

  fubb_fifo #(
    .WIDTH (QW),
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (q_push),
    .push_data  ({push_op, push_addr}),
    .full       (q_full),
    .pop        (q_pop),
    .head_valid (q_valid),
    .head_data  (q_head)
  );

  assign head_op   = q_head[QW-1:AW];
  assign head_addr = q_head[AW-1:0];

  fubb_back #(
    .BUF_DEPTH (BUF_DEPTH)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_valid   (q_valid),
    .q_op      (head_op),
    .q_addr    (head_addr),
    .q_pop     (q_pop),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

/* hdl/fubb_ram.sv */
module fubb_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 512
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

/* hdl/fubb_fifo.sv */
module fubb_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [WIDTH-1:0] push_data,
  output logic             full,
  input  logic             pop,
  output logic             head_valid,
  output logic [WIDTH-1:0] head_data
);

  localparam int PTRW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNTW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [PTRW-1:0]  wr_ptr_r, wr_ptr_nxt;
  logic [PTRW-1:0]  rd_ptr_r, rd_ptr_nxt;
  logic [CNTW-1:0]  count_r, count_nxt;

  assign full       = (count_r == CNTW'(DEPTH));
  assign head_valid = (count_r != '0);
  assign head_data  = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PTRW'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTRW'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

/* hdl/fubb_front.sv */
module fubb_front #(
  parameter int BUF_DEPTH = 512
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  fubb_pkg::in_item_t           in_data,
  input  logic                         cfg_valid,
  output logic                         cfg_ready,
  input  fubb_pkg::cap_t               cfg_capacity,
  input  logic                         q_full,
  output logic                         q_push,
  output fubb_pkg::op_t                q_op,
  output logic [$clog2(BUF_DEPTH)-1:0] q_addr
);

  import fubb_pkg::*;

  localparam int AW = $clog2(BUF_DEPTH);
  localparam int SW = ((AW > CAP_W) ? AW : CAP_W) + 1;
  localparam logic [SW-1:0] DEPTH_EXT = SW'(BUF_DEPTH);

  localparam logic [1:0] PH_IDLE  = 2'd0;
  localparam logic [1:0] PH_NAME  = 2'd1;
  localparam logic [1:0] PH_VALUE = 2'd2;

  logic [AW-1:0] wp_r, wp_nxt;
  logic [AW-1:0] ps_r, ps_nxt;
  logic [1:0]    phase_r, phase_nxt;
  logic          failed_r, failed_nxt;
  logic          vseen_r, vseen_nxt;
  logic          ovf_r, ovf_nxt;
  cap_t          cap_r;

  logic          pre_en;
  logic [7:0]    pre_byte;
  enc_t          enc;
  logic          try_write;
  logic [31:0]   full_bytes;
  logic [2:0]    n_total;
  logic [SW-1:0] cap_eff;
  logic [SW-1:0] ridx_ext;
  logic [1:0]    status;
  logic          hit;

  assign in_ready  = !q_full;
  assign cfg_ready = 1'b1;
  assign q_push    = in_valid && in_ready;

  assign cap_eff  = (SW'(cap_r) > DEPTH_EXT) ? DEPTH_EXT : SW'(cap_r);
  assign ridx_ext = SW'(in_data.read_index);

  always_comb begin
    wp_nxt     = wp_r;
    ps_nxt     = ps_r;
    phase_nxt  = phase_r;
    failed_nxt = failed_r;
    vseen_nxt  = vseen_r;
    ovf_nxt    = ovf_r;
    pre_en     = 1'b0;
    pre_byte   = CH_AMP;
    enc        = '0;
    try_write  = 1'b0;
    status     = ST_OK;
    hit        = 1'b0;
    full_bytes = '0;
    n_total    = '0;
    q_addr     = wp_r;

    unique case (in_data.action) inside
      ACT_CLEAR: begin
        wp_nxt     = '0;
        ps_nxt     = '0;
        phase_nxt  = PH_IDLE;
        failed_nxt = 1'b0;
        vseen_nxt  = 1'b0;
        ovf_nxt    = 1'b0;
      end
      ACT_NAME: begin
        // A name byte in the value part of a pair is dropped silently.
        if (phase_r != PH_VALUE) begin
          if (phase_r == PH_IDLE) begin
            ps_nxt     = wp_r;
            failed_nxt = 1'b0;
            vseen_nxt  = 1'b0;
            phase_nxt  = PH_NAME;
            pre_en     = (wp_r != '0);
            pre_byte   = CH_AMP;
          end
          if (phase_r != PH_IDLE && failed_r) begin
            status = ST_NO_ROOM;
          end else begin
            enc       = encode_text(in_data.data_byte);
            try_write = 1'b1;
          end
        end
      end
      ACT_TEXT, ACT_BIN: begin
        if (phase_r == PH_IDLE) begin
          status = ST_NO_NAME;
        end else begin
          pre_en    = (phase_r == PH_NAME);
          pre_byte  = CH_EQ;
          phase_nxt = PH_VALUE;
          vseen_nxt = 1'b1;
          if (failed_r) begin
            status = ST_NO_ROOM;
          end else begin
            enc = (in_data.action == ACT_TEXT) ? encode_text(in_data.data_byte)
                                               : encode_hex(in_data.data_byte);
            try_write = 1'b1;
          end
        end
      end
      ACT_END: begin
        if (phase_r == PH_IDLE) begin
          status = ST_NO_NAME;
        end else begin
          // The empty-value check wins over a failed pair.
          if (!vseen_r) begin
            wp_nxt = ps_r;
            status = ST_EMPTY_VAL;
          end else if (failed_r) begin
            ovf_nxt = 1'b1;
            status  = ST_NO_ROOM;
          end
          phase_nxt  = PH_IDLE;
          failed_nxt = 1'b0;
          vseen_nxt  = 1'b0;
        end
      end
      ACT_READ: begin
        hit    = (ridx_ext < SW'(wp_r)) && (ridx_ext < DEPTH_EXT);
        q_addr = ridx_ext[AW-1:0];
      end
      default: begin
      end
    endcase

    if (try_write) begin
      full_bytes = pre_en ? {pre_byte, enc.bytes} : {enc.bytes, 8'h00};
      n_total    = {2'b00, pre_en} + {1'b0, enc.n};
      // One byte is kept free, so reaching the capacity is a failure.
      if (SW'(wp_r) + SW'(n_total) >= cap_eff) begin
        wp_nxt     = ps_nxt;
        failed_nxt = 1'b1;
        status     = ST_NO_ROOM;
        n_total    = '0;
      end else begin
        wp_nxt = wp_r + AW'(n_total);
      end
    end

    q_op.n_bytes           = n_total;
    q_op.bytes             = full_bytes;
    q_op.read_hit          = hit;
    q_op.res.status        = status;
    q_op.res.read_data     = '0;
    q_op.res.body_length   = 9'(SW'(wp_nxt));
    q_op.res.overflow_seen = ovf_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r     <= '0;
      ps_r     <= '0;
      phase_r  <= PH_IDLE;
      failed_r <= 1'b0;
      vseen_r  <= 1'b0;
      ovf_r    <= 1'b0;
      cap_r    <= CAP_RESET;
    end else begin
      if (q_push) begin
        wp_r     <= wp_nxt;
        ps_r     <= ps_nxt;
        phase_r  <= phase_nxt;
        failed_r <= failed_nxt;
        vseen_r  <= vseen_nxt;
        ovf_r    <= ovf_nxt;
      end
      if (cfg_valid && cfg_ready) begin
        cap_r <= cfg_capacity;
      end
    end
  end

  a_start_below_pos: assert property (@(posedge clk) disable iff (!rst_n)
    ps_r <= wp_r)
    else $error("pair start lies beyond the write position");

  a_failed_rolled_back: assert property (@(posedge clk) disable iff (!rst_n)
    failed_r |-> (wp_r == ps_r))
    else $error("failed pair has bytes left in the store");

  a_failed_needs_pair: assert property (@(posedge clk) disable iff (!rst_n)
    failed_r |-> (phase_r != PH_IDLE))
    else $error("failure marked with no open pair");

endmodule

/* hdl/fubb_back.sv */
module fubb_back #(
  parameter int BUF_DEPTH = 512
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         q_valid,
  input  fubb_pkg::op_t                q_op,
  input  logic [$clog2(BUF_DEPTH)-1:0] q_addr,
  output logic                         q_pop,
  output logic                         out_valid,
  input  logic                         out_ready,
  output fubb_pkg::out_item_t          out_data
);

  import fubb_pkg::*;

  localparam int AW = $clog2(BUF_DEPTH);

  logic [1:0]  cnt_r, cnt_nxt;
  logic        p1_v_r;
  out_item_t   p1_res_r;
  logic        p1_hit_r;
  logic        out_v_r;
  out_item_t   out_r;

  logic        p1_move;
  logic        issue_ok;
  logic        step;
  logic        last;
  logic [31:0] lane;
  logic        ram_we;
  logic        ram_re;
  logic [7:0]  ram_rdata;
  out_item_t   p1_final;

  assign p1_move  = p1_v_r && (!out_v_r || out_ready);
  assign issue_ok = !p1_v_r || p1_move;
  assign step     = q_valid && issue_ok;
  assign last     = (q_op.n_bytes == 3'd0) || ({1'b0, cnt_r} == q_op.n_bytes - 3'd1);
  assign q_pop    = step && last;
  assign lane     = q_op.bytes << {cnt_r, 3'b000};
  assign ram_we   = step && (q_op.n_bytes != 3'd0);
  assign ram_re   = step && q_op.read_hit;
  assign cnt_nxt  = step ? (last ? 2'd0 : cnt_r + 2'd1) : cnt_r;

  fubb_ram #(
    .WIDTH (8),
    .DEPTH (BUF_DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (q_addr + AW'(cnt_r)),
    .wdata (lane[31:24]),
    .re    (ram_re),
    .raddr (q_addr),
    .rdata (ram_rdata)
  );

  // The store output holds while the stage waits, since no new read issues.
  always_comb begin
    p1_final           = p1_res_r;
    p1_final.read_data = p1_hit_r ? ram_rdata : 8'h00;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r   <= 2'd0;
      p1_v_r  <= 1'b0;
      out_v_r <= 1'b0;
    end else begin
      cnt_r <= cnt_nxt;
      if (q_pop) begin
        p1_v_r <= 1'b1;
      end else if (p1_move) begin
        p1_v_r <= 1'b0;
      end
      if (p1_move) begin
        out_v_r <= 1'b1;
      end else if (out_ready) begin
        out_v_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      p1_res_r <= q_op.res;
      p1_hit_r <= q_op.read_hit;
    end
    if (p1_move) begin
      out_r <= p1_final;
    end
  end

  assign out_valid = out_v_r;
  assign out_data  = out_r;

  a_burst_has_request: assert property (@(posedge clk) disable iff (!rst_n)
    (cnt_r != 2'd0) |-> (q_valid && ({1'b0, cnt_r} < q_op.n_bytes)))
    else $error("byte counter running without a matching request");

  a_single_store_op: assert property (@(posedge clk) disable iff (!rst_n)
    ram_re |-> !ram_we)
    else $error("store read and write issued in one cycle");

  a_stage_kept: assert property (@(posedge clk) disable iff (!rst_n)
    (p1_v_r && !p1_move) |=> (p1_v_r && $stable(p1_res_r)))
    else $error("waiting result lost or overwritten");

endmodule
